// ===== src/assert_macros.svh =====
// Concurrent assertion helpers for the fault monitor checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define DFM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that cond never holds at a rising clock edge outside reset.
`define DFM_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== src/dfm_pkg.sv =====
`timescale 1ns / 1ps

package dfm_pkg;

  localparam int unsigned IdxW        = 4;
  localparam int unsigned ValW        = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned FlagW       = 16;
  localparam int unsigned DefSlotCount = 16;

  // Relation codes; both ends of the range mean "no relation"
  typedef enum logic [OpW-1:0] {
    OpNone  = 3'd0,
    OpGt    = 3'd1,
    OpLt    = 3'd2,
    OpGe    = 3'd3,
    OpLe    = 3'd4,
    OpEq    = 3'd5,
    OpNe    = 3'd6,
    OpNoneH = 3'd7
  } rel_op_e;

  typedef enum logic [1:0] {
    SlotNone      = 2'd0,
    SlotOngoing   = 2'd1,
    SlotTriggered = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvStarted = 2'd1,
    EvStopped = 2'd2,
    EvExpired = 2'd3
  } timer_event_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the input word and read the deadline
    logic eval;  // evaluate the slot and update state and result
  } dfm_cmd_t;

  function automatic logic rel_holds(input logic [OpW-1:0] op,
                                     input logic signed [ValW-1:0] v,
                                     input logic signed [ValW-1:0] lim);
    logic r;
    case (rel_op_e'(op))
      OpGt:    r = (v > lim);
      OpLt:    r = (v < lim);
      OpGe:    r = (v >= lim);
      OpLe:    r = (v <= lim);
      OpEq:    r = (v == lim);
      OpNe:    r = (v != lim);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/dfm_ram.sv =====
`timescale 1ns / 1ps

module dfm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dfm_ctrl.sv =====
`timescale 1ns / 1ps

module dfm_ctrl import dfm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output dfm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEval = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        done_q;

  // Next state: take a word when idle, evaluate it in the following cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StEval;
      StEval:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StEval);
    end
  end

  assign busy       = (state_q == StEval);
  assign done_o     = done_q;
  assign cmd_o.load = (state_q == StIdle) && start;
  assign cmd_o.eval = (state_q == StEval);

endmodule

// ===== src/dfm_datapath.sv =====
`timescale 1ns / 1ps

module dfm_datapath import dfm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DefSlotCount
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dfm_cmd_t               cmd_i,
  input  logic                   cfg_we_i,
  input  logic [FlagW-1:0]       cfg_data_i,
  input  logic [IdxW-1:0]        fault_index_i,
  input  logic [ValW-1:0]        now_ms_i,
  input  logic signed [ValW-1:0] value_a_i,
  input  logic [OpW-1:0]         op_a_i,
  input  logic signed [ValW-1:0] limit_a_i,
  input  logic signed [ValW-1:0] value_b_i,
  input  logic [OpW-1:0]         op_b_i,
  input  logic signed [ValW-1:0] limit_b_i,
  input  logic [ValW-1:0]        timeout_ms_i,
  output logic [1:0]             slot_state_o,
  output logic [1:0]             timer_event_o,
  output logic signed [ValW-1:0] event_value_o,
  output logic                   critical_triggered_o,
  output logic [FlagW-1:0]       fault_bits_o,
  output logic                   critical_active_o
);

  localparam int unsigned AddrW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Captured input word
  logic [IdxW-1:0]        idx_q;
  logic [ValW-1:0]        now_q;
  logic signed [ValW-1:0] va_q, la_q, vb_q, lb_q;
  logic [OpW-1:0]         opa_q, opb_q;
  logic [ValW-1:0]        tmo_q;

  // Slot state
  logic [SLOT_COUNT-1:0]  run_q, run_d;
  logic [FlagW-1:0]       fault_bits_q, fault_bits_d;
  logic [FlagW-1:0]       mask_q;

  // Result register
  logic [1:0]             st_q, ev_q;
  logic signed [ValW-1:0] ev_val_q;
  logic                   crit_trig_q, crit_act_q;
  logic [FlagW-1:0]       fb_out_q;

  logic [AddrW-1:0]       slot_addr;
  logic [ValW-1:0]        deadline_rd;
  logic [ValW-1:0]        deadline_wr;
  logic [ValW-1:0]        late_by;
  logic                   in_range, b_none, present, running, reached;
  logic                   ram_we, crit_trig;
  logic [FlagW-1:0]       slot_bit;
  slot_state_e            st;
  timer_event_e           ev;

  // Deadline store, read at capture, written during evaluation
  dfm_ram #(
    .Width (ValW),
    .Depth (SLOT_COUNT)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_addr),
    .wdata_i (deadline_wr),
    .raddr_i (AddrW'(fault_index_i)),
    .rdata_o (deadline_rd)
  );

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= fault_index_i;
      now_q <= now_ms_i;
      va_q  <= value_a_i;
      opa_q <= op_a_i;
      la_q  <= limit_a_i;
      vb_q  <= value_b_i;
      opb_q <= op_b_i;
      lb_q  <= limit_b_i;
      tmo_q <= timeout_ms_i;
    end
  end

  // Evaluate the slot
  assign slot_addr   = AddrW'(idx_q);
  assign in_range    = (32'(idx_q) < SLOT_COUNT);
  assign b_none      = (opb_q == OpNone) || (opb_q == OpNoneH);
  assign present     = rel_holds(opa_q, va_q, la_q) &&
                       (b_none || rel_holds(opb_q, vb_q, lb_q));
  assign running     = in_range && run_q[slot_addr];
  assign late_by     = now_q - deadline_rd;
  assign reached     = !late_by[ValW-1];
  assign deadline_wr = now_q + tmo_q;
  assign slot_bit    = FlagW'(1) << idx_q;

  always_comb begin
    st = SlotNone;
    ev = EvNone;
    if (in_range) begin
      if (!present) begin
        if (running) ev = EvStopped;
      end else if (!running) begin
        ev = EvStarted;
        st = SlotOngoing;
      end else if (reached) begin
        ev = EvExpired;
        st = SlotTriggered;
      end else begin
        st = SlotOngoing;
      end
    end
  end

  assign ram_we    = cmd_i.eval && (ev == EvStarted);
  assign crit_trig = (st == SlotTriggered) && |(mask_q & slot_bit);

  // Update the running flags and latched fault flags
  always_comb begin
    run_d        = run_q;
    fault_bits_d = fault_bits_q;
    if (cmd_i.eval && in_range) begin
      if (ev == EvStarted) begin
        run_d[slot_addr] = 1'b1;
      end else if (ev == EvStopped || ev == EvExpired) begin
        run_d[slot_addr] = 1'b0;
      end
      if (st == SlotNone) begin
        fault_bits_d = fault_bits_q & ~slot_bit;
      end else if (st == SlotTriggered) begin
        fault_bits_d = fault_bits_q | slot_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      fault_bits_q <= '0;
      mask_q       <= '1;
    end else begin
      run_q        <= run_d;
      fault_bits_q <= fault_bits_d;
      if (cfg_we_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      st_q        <= st;
      ev_q        <= ev;
      ev_val_q    <= (ev != EvNone) ? va_q : '0;
      crit_trig_q <= crit_trig;
      fb_out_q    <= fault_bits_d;
      crit_act_q  <= |(fault_bits_d & mask_q);
    end
  end

  assign slot_state_o         = st_q;
  assign timer_event_o        = ev_q;
  assign event_value_o        = ev_val_q;
  assign critical_triggered_o = crit_trig_q;
  assign fault_bits_o         = fb_out_q;
  assign critical_active_o    = crit_act_q;

endmodule

// ===== src/debounced_fault_monitor_unit.sv =====
`timescale 1ns / 1ps

// Debounced threshold fault monitor. Pulse start with a fault word while busy
// is low; each word evaluates one fault slot and yields exactly one result,
// shown for one cycle under done_o, registered after the evaluate state that
// follows acceptance. The receiver cannot stall, so it must take the result
// in that cycle. A word is handled in order: the slot's deadline is first read
// from its registered-read RAM, then the slot is evaluated and written back. A
// new word may be started in the cycle its predecessor's result is shown.
// critical_mask is written over the cfg channel, which is always ready.
module debounced_fault_monitor_unit import dfm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DefSlotCount
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   done_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FlagW-1:0]       cfg_data_i,
  input  logic [IdxW-1:0]        fault_index_i,
  input  logic [ValW-1:0]        now_ms_i,
  input  logic signed [ValW-1:0] value_a_i,
  input  logic [OpW-1:0]         op_a_i,
  input  logic signed [ValW-1:0] limit_a_i,
  input  logic signed [ValW-1:0] value_b_i,
  input  logic [OpW-1:0]         op_b_i,
  input  logic signed [ValW-1:0] limit_b_i,
  input  logic [ValW-1:0]        timeout_ms_i,
  output logic [1:0]             slot_state_o,
  output logic [1:0]             timer_event_o,
  output logic signed [ValW-1:0] event_value_o,
  output logic                   critical_triggered_o,
  output logic [FlagW-1:0]       fault_bits_o,
  output logic                   critical_active_o
);

  dfm_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  dfm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  dfm_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .fault_index_i        (fault_index_i),
    .now_ms_i             (now_ms_i),
    .value_a_i            (value_a_i),
    .op_a_i               (op_a_i),
    .limit_a_i            (limit_a_i),
    .value_b_i            (value_b_i),
    .op_b_i               (op_b_i),
    .limit_b_i            (limit_b_i),
    .timeout_ms_i         (timeout_ms_i),
    .slot_state_o         (slot_state_o),
    .timer_event_o        (timer_event_o),
    .event_value_o        (event_value_o),
    .critical_triggered_o (critical_triggered_o),
    .fault_bits_o         (fault_bits_o),
    .critical_active_o    (critical_active_o)
  );

endmodule

// ===== src/dfm_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dfm_checker import dfm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [1:0]             slot_state_o,
  input logic [1:0]             timer_event_o,
  input logic signed [ValW-1:0] event_value_o,
  input logic                   critical_triggered_o,
  input logic                   critical_active_o
);

  // An accepted word keeps the unit busy for one cycle, then reports
  `DFM_ASSERT(a_accept_then_busy, clk_i, rst_ni, (start && !busy) |=> (busy && !done_o))
  `DFM_ASSERT(a_busy_then_done, clk_i, rst_ni, busy |=> (done_o && !busy))

  // No event means no echoed value
  `DFM_ASSERT(a_quiet_value, clk_i, rst_ni,
    (done_o && (timer_event_o == EvNone)) |-> (event_value_o == '0))

  // A critical trigger is a trigger and shows in the summary flag
  `DFM_ASSERT(a_crit_trig, clk_i, rst_ni,
    (done_o && critical_triggered_o) |->
      ((slot_state_o == SlotTriggered) && critical_active_o))

  // Slot state and timer event agree
  `DFM_ASSERT_NEVER(a_state_event, clk_i, rst_ni,
    done_o && (slot_state_o == SlotTriggered) && (timer_event_o != EvExpired))

endmodule

bind debounced_fault_monitor_unit dfm_checker u_dfm_checker (.*);

// ===== verif/tb_debounced_fault_monitor_unit.sv =====
`timescale 1ns / 1ps

module tb_debounced_fault_monitor_unit;
  import dfm_pkg::*;

  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
  localparam int unsigned RandWordsPerPhase = 190;

  typedef struct packed {
    logic [IdxW-1:0]        slot;
    logic [ValW-1:0]        now;
    logic signed [ValW-1:0] va;
    rel_op_e                opa;
    logic signed [ValW-1:0] la;
    logic signed [ValW-1:0] vb;
    rel_op_e                opb;
    logic signed [ValW-1:0] lb;
    logic [ValW-1:0]        tmo;
  } fault_word_t;

  typedef struct packed {
    slot_state_e            state;
    timer_event_e           ev;
    logic signed [ValW-1:0] ev_val;
    logic                   crit_trig;
    logic [FlagW-1:0]       flags;
    logic                   crit_act;
  } slot_report_t;

  typedef enum logic [1:0] {
    ActWord,
    ActMask,
    ActDrain
  } act_kind_e;

  typedef struct packed {
    act_kind_e        kind;
    logic [FlagW-1:0] mask;
    fault_word_t      word;
  } stim_act_t;

  // Clock, reset and block inputs
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [FlagW-1:0] cfg_data_i = '0;
  logic [IdxW-1:0] fault_index_i = '0;
  logic [ValW-1:0] now_ms_i = '0;
  logic signed [ValW-1:0] value_a_i = '0;
  logic [OpW-1:0] op_a_i = '0;
  logic signed [ValW-1:0] limit_a_i = '0;
  logic signed [ValW-1:0] value_b_i = '0;
  logic [OpW-1:0] op_b_i = '0;
  logic signed [ValW-1:0] limit_b_i = '0;
  logic [ValW-1:0] timeout_ms_i = '0;

  // Block outputs
  logic busy;
  logic done_o;
  logic cfg_ready_o;
  logic [1:0] slot_state_o;
  logic [1:0] timer_event_o;
  logic signed [ValW-1:0] event_value_o;
  logic critical_triggered_o;
  logic [FlagW-1:0] fault_bits_o;
  logic critical_active_o;

  // Monitor model state
  logic timer_on_m [DefSlotCount];
  logic [ValW-1:0] due_m [DefSlotCount];
  logic [FlagW-1:0] flags_m = '0;
  logic [FlagW-1:0] mask_m = 16'hFFFF;

  stim_act_t stim_q[$];
  slot_report_t report_q[$];
  slot_report_t want_r;
  stim_act_t cur_act;
  fault_word_t cur_word;
  logic start_nx;
  logic cfg_nx;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned err_cnt = 0;
  logic [ValW-1:0] gen_now;

  debounced_fault_monitor_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .done_o               (done_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .fault_index_i        (fault_index_i),
    .now_ms_i             (now_ms_i),
    .value_a_i            (value_a_i),
    .op_a_i               (op_a_i),
    .limit_a_i            (limit_a_i),
    .value_b_i            (value_b_i),
    .op_b_i               (op_b_i),
    .limit_b_i            (limit_b_i),
    .timeout_ms_i         (timeout_ms_i),
    .slot_state_o         (slot_state_o),
    .timer_event_o        (timer_event_o),
    .event_value_o        (event_value_o),
    .critical_triggered_o (critical_triggered_o),
    .fault_bits_o         (fault_bits_o),
    .critical_active_o    (critical_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < DefSlotCount; i++) begin
      timer_on_m[i] = 1'b0;
      due_m[i] = '0;
    end
  end

  // Signed relation test; both none codes never hold
  function automatic logic rel_true(input rel_op_e op, input logic signed [ValW-1:0] v,
                                    input logic signed [ValW-1:0] lim);
    case (op)
      OpGt:    return v > lim;
      OpLt:    return v < lim;
      OpGe:    return v >= lim;
      OpLe:    return v <= lim;
      OpEq:    return v == lim;
      OpNe:    return v != lim;
      default: return 1'b0;
    endcase
  endfunction

  // Swap a relation for its complement when it does not give the wanted outcome
  function automatic rel_op_e fit_rel(input rel_op_e op, input logic signed [ValW-1:0] v,
                                      input logic signed [ValW-1:0] lim, input logic want);
    if (rel_true(op, v, lim) == want) return op;
    case (op)
      OpGt:    return OpLe;
      OpLe:    return OpGt;
      OpLt:    return OpGe;
      OpGe:    return OpLt;
      OpEq:    return OpNe;
      default: return OpEq;
    endcase
  endfunction

  // Evaluate one slot word against the model and advance its state
  function automatic slot_report_t evaluate_slot(input fault_word_t w);
    slot_report_t r;
    logic present;
    logic [ValW-1:0] lag;
    present = rel_true(w.opa, w.va, w.la) &&
              (w.opb == OpNone || w.opb == OpNoneH || rel_true(w.opb, w.vb, w.lb));
    r.state = SlotNone;
    r.ev = EvNone;
    if (!present) begin
      if (timer_on_m[w.slot]) begin
        timer_on_m[w.slot] = 1'b0;
        r.ev = EvStopped;
      end
    end else if (!timer_on_m[w.slot]) begin
      timer_on_m[w.slot] = 1'b1;
      due_m[w.slot] = w.now + w.tmo;
      r.ev = EvStarted;
      r.state = SlotOngoing;
    end else begin
      lag = w.now - due_m[w.slot];
      if (!lag[ValW-1]) begin
        timer_on_m[w.slot] = 1'b0;
        r.ev = EvExpired;
        r.state = SlotTriggered;
      end else begin
        r.state = SlotOngoing;
      end
    end
    if (r.state == SlotNone) flags_m[w.slot] = 1'b0;
    else if (r.state == SlotTriggered) flags_m[w.slot] = 1'b1;
    r.crit_trig = (r.state == SlotTriggered) && mask_m[w.slot];
    r.ev_val = (r.ev != EvNone) ? w.va : '0;
    r.flags = flags_m;
    r.crit_act = |(flags_m & mask_m);
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] rand_val();
    case ($urandom_range(0, 7))
      0:       return ValMax;
      1:       return ValMin;
      2:       return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Pick a limit near the value so that equality and off-by-one cases show up
  function automatic logic signed [ValW-1:0] rand_limit(input logic signed [ValW-1:0] v);
    case ($urandom_range(0, 5))
      0:       return v;
      1:       return v + 1;
      2:       return v - 1;
      default: return rand_val();
    endcase
  endfunction

  // Build a word for a slot whose fault is present or absent as asked
  function automatic fault_word_t make_word(input logic [IdxW-1:0] slot, input logic [ValW-1:0] now,
                                            input logic [ValW-1:0] tmo, input logic present);
    fault_word_t w;
    w.slot = slot;
    w.now = now;
    w.tmo = tmo;
    w.va = rand_val();
    w.la = rand_limit(w.va);
    w.vb = rand_val();
    w.lb = rand_limit(w.vb);
    w.opa = fit_rel(rel_op_e'($urandom_range(1, 6)), w.va, w.la, 1'b1);
    w.opb = rel_op_e'($urandom_range(0, 7));
    if (present) begin
      if ($urandom_range(0, 2) == 0) w.opb = $urandom_range(0, 1) ? OpNone : OpNoneH;
      else w.opb = fit_rel(rel_op_e'($urandom_range(1, 6)), w.vb, w.lb, 1'b1);
    end else begin
      case ($urandom_range(0, 2))
        0:       w.opa = $urandom_range(0, 1) ? OpNone : OpNoneH;
        1:       w.opa = fit_rel(w.opa, w.va, w.la, 1'b0);
        default: w.opb = fit_rel(rel_op_e'($urandom_range(1, 6)), w.vb, w.lb, 1'b0);
      endcase
    end
    return w;
  endfunction

  function automatic void push_word(input fault_word_t w);
    stim_act_t a;
    a.kind = ActWord;
    a.mask = '0;
    a.word = w;
    stim_q.push_back(a);
  endfunction

  function automatic void push_act(input act_kind_e kind, input logic [FlagW-1:0] mask);
    stim_act_t a;
    a.kind = kind;
    a.mask = mask;
    a.word = '0;
    stim_q.push_back(a);
  endfunction

  function automatic void queue_word(input logic [IdxW-1:0] slot, input logic [ValW-1:0] now,
                                     input logic signed [ValW-1:0] va, input rel_op_e opa,
                                     input logic signed [ValW-1:0] la,
                                     input logic signed [ValW-1:0] vb, input rel_op_e opb,
                                     input logic signed [ValW-1:0] lb, input logic [ValW-1:0] tmo);
    fault_word_t w;
    w = '{slot: slot, now: now, va: va, opa: opa, la: la, vb: vb, opb: opb, lb: lb, tmo: tmo};
    push_word(w);
  endfunction

  function automatic void log_mismatch(input string msg);
    if (err_cnt < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endfunction

  // Driver: present queued words in bursts, write the mask only when idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      start_nx = start;
      cfg_nx = cfg_valid_i;
      if (start && !busy) begin
        report_q.push_back(evaluate_slot(cur_word));
        start_nx = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        mask_m = cfg_data_i;
        cfg_nx = 1'b0;
      end
      if (!start_nx && !cfg_nx && stim_q.size() != 0) begin
        case (stim_q[0].kind)
          ActWord: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              cur_act = stim_q.pop_front();
              cur_word = cur_act.word;
              fault_index_i <= cur_word.slot;
              now_ms_i <= cur_word.now;
              value_a_i <= cur_word.va;
              op_a_i <= cur_word.opa;
              limit_a_i <= cur_word.la;
              value_b_i <= cur_word.vb;
              op_b_i <= cur_word.opb;
              limit_b_i <= cur_word.lb;
              timeout_ms_i <= cur_word.tmo;
              start_nx = 1'b1;
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
              end
            end
          end
          ActMask: begin
            if (report_q.size() == 0 && !busy) begin
              cur_act = stim_q.pop_front();
              cfg_data_i <= cur_act.mask;
              cfg_nx = 1'b1;
            end
          end
          default: begin
            if (report_q.size() == 0) void'(stim_q.pop_front());
          end
        endcase
      end
      start <= start_nx;
      cfg_valid_i <= cfg_nx;
    end
  end

  // Monitor: check every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (report_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result state %0d event %0d value %0d flags %h",
                               slot_state_o, timer_event_o, event_value_o, fault_bits_o));
      end else begin
        want_r = report_q.pop_front();
        if (slot_state_o !== want_r.state || timer_event_o !== want_r.ev ||
            event_value_o !== want_r.ev_val || critical_triggered_o !== want_r.crit_trig ||
            fault_bits_o !== want_r.flags || critical_active_o !== want_r.crit_act) begin
          log_mismatch($sformatf(
            "exp st %0d ev %0d val %0d ct %0b fb %h ca %0b / got st %0d ev %0d val %0d ct %0b fb %h ca %0b",
            want_r.state, want_r.ev, want_r.ev_val, want_r.crit_trig, want_r.flags,
            want_r.crit_act, slot_state_o, timer_event_o, event_value_o,
            critical_triggered_o, fault_bits_o, critical_active_o));
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [FlagW-1:0] phase_mask [6];
    logic [IdxW-1:0] slot;
    logic [ValW-1:0] tmo;
    int unsigned words;
    int unsigned len;
    int unsigned drain_at;

    phase_mask[0] = 16'h0000;
    phase_mask[1] = 16'hFFFF;
    phase_mask[2] = 16'h5555;
    phase_mask[3] = 16'hAAAA;
    phase_mask[4] = FlagW'($urandom);
    phase_mask[5] = FlagW'($urandom);

    push_act(ActMask, 16'hFFFF);

    // Start, then expire at the same time stamp with a zero timeout, then clear the flag
    queue_word(4'd0, 32'd1000, ValMax, OpGt, ValMin, 32'sd0, OpNone, 32'sd0, 32'd0);
    queue_word(4'd0, 32'd1000, ValMax, OpGt, ValMin, 32'sd0, OpNone, 32'sd0, 32'd0);
    queue_word(4'd0, 32'd1001, ValMax, OpNone, ValMin, 32'sd0, OpNone, 32'sd0, 32'd0);
    // Start, hold ongoing, then stop through the second relation
    queue_word(4'd1, 32'd1000, ValMin, OpLt, ValMax, ValMin, OpEq, ValMin, 32'd100);
    queue_word(4'd1, 32'd1050, ValMin, OpLt, ValMax, ValMin, OpLt, ValMax, 32'd100);
    queue_word(4'd1, 32'd1060, ValMin, OpLt, ValMax, ValMin, OpNe, ValMin, 32'd100);
    // Half-range timeout stays pending on the next step
    queue_word(4'd2, 32'd5, ValMin, OpGe, ValMin, ValMax, OpLe, ValMax, 32'h8000_0000);
    queue_word(4'd2, 32'd6, ValMin, OpGe, ValMin, ValMax, OpLe, ValMax, 32'h8000_0000);
    // Full-range timeout expires on the next step
    queue_word(4'd5, 32'd50, 32'sd7, OpGe, 32'sd7, 32'sd0, OpNoneH, 32'sd0, 32'hFFFF_FFFF);
    queue_word(4'd5, 32'd51, 32'sd7, OpGe, 32'sd7, 32'sd0, OpNoneH, 32'sd0, 32'hFFFF_FFFF);
    // Deadline across the time wrap
    queue_word(4'd3, 32'hFFFF_FFF0, 32'sd0, OpEq, 32'sd0, 32'sd0, OpNoneH, 32'sd0, 32'd20);
    queue_word(4'd3, 32'h0000_0003, 32'sd0, OpEq, 32'sd0, 32'sd0, OpNoneH, 32'sd0, 32'd20);
    queue_word(4'd3, 32'h0000_0004, 32'sd0, OpEq, 32'sd0, 32'sd0, OpNoneH, 32'sd0, 32'd20);
    queue_word(4'd3, 32'h0000_0005, 32'sd0, OpNe, 32'sd0, 32'sd0, OpNoneH, 32'sd0, 32'd20);
    queue_word(4'd4, 32'd9, ValMax, OpNoneH, ValMax, ValMax, OpGt, ValMin, 32'd0);
    // Deadline one short, then reached, then a fresh start with the flag held
    queue_word(4'd15, 32'd100, -32'sd1, OpLe, 32'sd0, 32'sd1, OpGt, 32'sd0, 32'd10);
    queue_word(4'd15, 32'd109, -32'sd1, OpLe, 32'sd0, 32'sd1, OpGt, 32'sd0, 32'd10);
    queue_word(4'd15, 32'd110, -32'sd1, OpLe, 32'sd0, 32'sd1, OpGt, 32'sd0, 32'd10);
    queue_word(4'd15, 32'd111, -32'sd1, OpLe, 32'sd0, 32'sd1, OpGt, 32'sd0, 32'd10);
    queue_word(4'd7, 32'd120, ValMax, OpGt, ValMax, 32'sd0, OpNone, 32'sd0, 32'd3);
    queue_word(4'd2, 32'd7, ValMin, OpGe, ValMin, ValMax, OpLe, ValMax, 32'h8000_0000);
    queue_word(4'd8, 32'd130, ValMax, OpGt, ValMax - 1, ValMin, OpGe, ValMin + 1, 32'd1);
    push_act(ActDrain, '0);

    // Random phases: mostly debounce sequences per slot, some lone and raw words
    gen_now = $urandom;
    for (int p = 0; p < 6; p++) begin
      push_act(ActMask, phase_mask[p]);
      if (p % 2 == 1) gen_now = 32'hFFFF_FF00 + $urandom_range(0, 200);
      drain_at = $urandom_range(40, RandWordsPerPhase - 40);
      words = 0;
      while (words < RandWordsPerPhase) begin
        if (words >= drain_at && drain_at != 0) begin
          push_act(ActDrain, '0);
          drain_at = 0;
        end
        case ($urandom_range(0, 9))
          0: begin
            push_word(fault_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom}));
            words++;
          end
          1: begin
            push_word(make_word(IdxW'($urandom), gen_now, $urandom,
                                1'($urandom_range(0, 1))));
            words++;
          end
          default: begin
            slot = IdxW'($urandom);
            case ($urandom_range(0, 9))
              0:       tmo = 0;
              1, 2, 3: tmo = $urandom_range(1, 15);
              4, 5:    tmo = $urandom_range(16, 120);
              6:       tmo = 32'h8000_0000 + $urandom_range(0, 3);
              7:       tmo = 32'hFFFF_FFFF - $urandom_range(0, 3);
              default: tmo = $urandom;
            endcase
            len = $urandom_range(2, 9);
            for (int k = 0; k < len; k++) begin
              gen_now += $urandom_range(0, 12);
              push_word(make_word(slot, gen_now, tmo, $urandom_range(0, 9) < 8));
              words++;
            end
          end
        endcase
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all words to be taken and every result to come back
    while (stim_q.size() != 0 || start || cfg_valid_i || report_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_debounced_fault_monitor_unit: done, clean");
    end else begin
      $display("tb_debounced_fault_monitor_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_debounced_fault_monitor_unit: done, errors");
    $finish;
  end

endmodule
